[rtl/vfsor_pkg.sv]
// Shared types, codes and helper functions of the vector field relaxation core.
package vfsor_pkg;

    // Default grid bounds
    localparam int DEF_MAX_X = 32;
    localparam int DEF_MAX_Y = 32;
    localparam int DEF_MAX_Z = 32;

    // Coordinate, linear index, weight and weight-sum widths
    localparam int CW    = 6;
    localparam int LIN_W = 18;
    localparam int WW    = 24;
    localparam int DENW  = 27;

    // Request modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_FILL  = 2'd1;
    localparam logic [1:0] MODE_RELAX = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_READ      = 3'd0;
    localparam logic [2:0] STAT_FILL_DONE = 3'd1;
    localparam logic [2:0] STAT_CONVERGED = 3'd2;
    localparam logic [2:0] STAT_LIMIT     = 3'd3;
    localparam logic [2:0] STAT_NO_CONSTR = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_WEIGHT_X   = 3'd0;
    localparam logic [2:0] REG_WEIGHT_Y   = 3'd1;
    localparam logic [2:0] REG_WEIGHT_Z   = 3'd2;
    localparam logic [2:0] REG_PRECISION  = 3'd3;
    localparam logic [2:0] REG_MAX_SWEEPS = 3'd4;
    localparam logic [2:0] REG_SIZE_X     = 3'd5;
    localparam logic [2:0] REG_SIZE_Y     = 3'd6;
    localparam logic [2:0] REG_SIZE_Z     = 3'd7;

    // Register reset values
    localparam logic [23:0] RST_WEIGHT     = 24'd65536;
    localparam logic [30:0] RST_PRECISION  = 31'd655;
    localparam logic [15:0] RST_MAX_SWEEPS = 16'd1000;
    localparam logic [5:0]  RST_SIZE       = 6'd32;

    typedef struct packed {
        logic [1:0]         mode;
        logic [14:0]        voxel_index;
        logic               is_constrained;
        logic signed [31:0] init_x;
        logic signed [31:0] init_y;
        logic signed [31:0] init_z;
        logic signed [31:0] fixed_x;
        logic signed [31:0] fixed_y;
        logic signed [31:0] fixed_z;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [15:0]        sweeps_used;
    } out_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic [DENW-1:0]    den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_INIT_RD, S_INIT_WR, S_INIT_END, S_SWEEP, S_VOX, S_CENTER,
        S_NB_RD, S_NB_MUL, S_NB_ACC, S_DIV_GO, S_DIV_WAIT, S_FILL_WR, S_RLX_D3,
        S_RLX_HALF, S_RLX_WR, S_RLX_ABS, S_RLX_SQ, S_RLX_CMP, S_NEXT, S_FINISH
    } state_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Raster index x + nx*(y + ny*z)
    function automatic logic [LIN_W-1:0] lin_index(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y,
                                                   input logic [CW-1:0] z,
                                                   input logic [CW-1:0] nx,
                                                   input logic [CW-1:0] ny);
        logic [11:0] inner;
        inner = 12'(y) + 12'(ny) * 12'(z);
        return LIN_W'(x) + LIN_W'(nx) * LIN_W'(inner);
    endfunction

endpackage

[rtl/vfsor_ram.sv]
// Generic simple dual-port RAM with registered read.
module vfsor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/vfsor_div.sv]
// Bit-serial rounding divider: round(num/den) ties away from zero, saturated to 32 bits.
module vfsor_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  vfsor_pkg::div_req_t req,
    output vfsor_pkg::div_rsp_t rsp
);
    logic                         busy_reg;
    logic                         done_reg;
    logic [5:0]                   cnt_reg;
    logic                         neg_reg;
    logic [vfsor_pkg::DENW-1:0]   den_reg;
    logic [vfsor_pkg::DENW-1:0]   rem_reg;
    logic [63:0]                  quo_reg;
    logic [vfsor_pkg::DENW:0]     rem_sh;
    logic                         fits;
    logic [63:0]                  mag;

    // One quotient bit per cycle
    always_comb begin
        rem_sh = {rem_reg, quo_reg[63]};
        fits   = rem_sh >= {1'b0, den_reg};
        mag    = req.num[63] ? 64'(-req.num) : 64'(req.num);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 6'd63) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= '0;
            neg_reg <= req.num[63];
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= mag + 64'(req.den >> 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            quo_reg <= {quo_reg[62:0], fits};
            rem_reg <= fits ? vfsor_pkg::DENW'(rem_sh - {1'b0, den_reg})
                            : rem_sh[vfsor_pkg::DENW-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = vfsor_pkg::sat32(neg_reg ? -$signed(quo_reg) : $signed(quo_reg));
endmodule

[rtl/vector_field_constrained_sor_core.sv]
// Top level: voxel stores, sweep sequencer and relaxation datapath.
//
// Usage: requests enter on s_valid/s_ready (payload s_data), results leave on
// m_valid/m_ready (payload m_data). Registers are written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must do so only while the core is idle,
// which the core does not enforce. A load request writes an in-range voxel in
// the cycle it is accepted, no result; a read result waits in S_READ for the
// output register. A fill request first sweeps all in-use voxels to clear
// the visited marks and seed constrained voxels, then runs raster sweeps.
// Fill and relax sweeps go straight past a skipped voxel and rewrite a constrained
// one from its fixed value; a free one takes six neighbor reads and multiplies,
// then three passes of the shared bit-serial divider, which set its cost;
// relaxation adds a change test. A run gives one result at the end.
// Requests are taken only while the sequencer is idle; a finished result waits
// in the output register while the next request is accepted, and a stalled
// receiver holds the core only when a second result is ready to go out.
// Reset restores the register defaults and empties the output; the voxel
// stores are not cleared.
module vector_field_constrained_sor_core #(
    parameter int MAX_X = vfsor_pkg::DEF_MAX_X,
    parameter int MAX_Y = vfsor_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vfsor_pkg::DEF_MAX_Z
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [30:0]      cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  vfsor_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output vfsor_pkg::out_t  m_data
);
    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CW    = vfsor_pkg::CW;
    localparam int LW    = vfsor_pkg::LIN_W;

    // Neighbor directions
    localparam logic [2:0] DIR_XP = 3'd0;
    localparam logic [2:0] DIR_XM = 3'd1;
    localparam logic [2:0] DIR_YP = 3'd2;
    localparam logic [2:0] DIR_YM = 3'd3;
    localparam logic [2:0] DIR_ZP = 3'd4;
    localparam logic [2:0] DIR_LAST = 3'd5;

    // Configuration registers
    logic [23:0] weight_x_reg, weight_y_reg, weight_z_reg;
    logic [30:0] precision_reg;
    logic [15:0] max_sweeps_reg;
    logic [5:0]  size_x_reg, size_y_reg, size_z_reg;

    vfsor_pkg::state_t state_reg, state_next;

    logic             m_valid_reg;
    vfsor_pkg::out_t  m_data_reg;
    logic             out_load;
    vfsor_pkg::out_t  out_word;

    logic             run_fill_reg;
    logic             in_range_reg;
    logic [LW-1:0]    i_reg;
    logic [LW-1:0]    count_reg;
    logic [15:0]      sweeps_reg;
    logic             settled_reg;
    logic             colour_reg;
    logic [2:0]       status_reg;
    logic [CW-1:0]    x_reg, y_reg, z_reg;
    logic [2:0]       d_reg;
    logic [1:0]       comp_reg;
    logic [1:0]       k_reg;
    logic             vp_reg;
    logic             use_reg;
    logic [vfsor_pkg::DENW-1:0] ws_reg;

    logic signed [31:0] old_reg  [0:2];
    logic signed [31:0] mean_reg [0:2];
    logic signed [63:0] sum_reg  [0:2];
    logic signed [56:0] prod_reg [0:2];
    logic signed [34:0] d3_reg   [0:2];
    logic signed [34:0] half_reg [0:2];
    logic signed [33:0] ch_reg   [0:2];
    logic [30:0]        abs_reg  [0:2];
    logic [61:0]        sq_reg;
    logic [63:0]        sq_sum_reg;

    // Derived geometry and weights
    logic [CW-1:0] nx, ny, nz;
    logic [LW-1:0] n_vox;
    logic [23:0]   wx, wy, wz, w_sel;
    logic [15:0]   max_eff;
    logic [vfsor_pkg::DENW-1:0] ws_relax;

    // Addressing
    logic [CW-1:0] nbx, nby, nbz;
    logic          nb_self;
    logic [LW-1:0] ctr_lin, nb_lin, rd_lin, wr_lin;
    logic          last_vox, skip_vox, in_range;

    // Memory ports
    logic          rd_en;
    logic          disp_we, fix_we, vis_we;
    logic [95:0]   disp_wdata, disp_rdata;
    logic [96:0]   fix_wdata, fix_rdata;
    logic [0:0]    vis_wdata, vis_rdata;

    // Relaxation datapath
    logic signed [31:0] nv   [0:2];
    logic signed [33:0] ch_w [0:2];
    logic [33:0]        abs_w [0:2];
    logic               gt_any;
    logic [30:0]        sq_op;

    vfsor_pkg::div_req_t div_req;
    vfsor_pkg::div_rsp_t div_rsp;

    // Clamp sizes and weights
    always_comb begin
        nx = (size_x_reg == '0) ? CW'(1) :
             ({3'b0, size_x_reg} > 9'(MAX_X)) ? CW'(MAX_X) : size_x_reg;
        ny = (size_y_reg == '0) ? CW'(1) :
             ({3'b0, size_y_reg} > 9'(MAX_Y)) ? CW'(MAX_Y) : size_y_reg;
        nz = (size_z_reg == '0) ? CW'(1) :
             ({3'b0, size_z_reg} > 9'(MAX_Z)) ? CW'(MAX_Z) : size_z_reg;
        n_vox    = LW'(nx) * LW'(ny) * LW'(nz);
        wx       = (weight_x_reg == '0) ? 24'd1 : weight_x_reg;
        wy       = (weight_y_reg == '0) ? 24'd1 : weight_y_reg;
        wz       = (weight_z_reg == '0) ? 24'd1 : weight_z_reg;
        max_eff  = (max_sweeps_reg == '0) ? 16'd1 : max_sweeps_reg;
        ws_relax = {26'(wx) + 26'(wy) + 26'(wz), 1'b0};
        in_range = {3'b0, s_data.voxel_index} < n_vox;
    end

    // Neighbor with edge replication
    always_comb begin
        nbx = x_reg;
        nby = y_reg;
        nbz = z_reg;
        case (d_reg)
            DIR_XP:  if (7'(x_reg) + 7'd1 < 7'(nx)) nbx = x_reg + CW'(1);
            DIR_XM:  if (x_reg != '0) nbx = x_reg - CW'(1);
            DIR_YP:  if (7'(y_reg) + 7'd1 < 7'(ny)) nby = y_reg + CW'(1);
            DIR_YM:  if (y_reg != '0) nby = y_reg - CW'(1);
            DIR_ZP:  if (7'(z_reg) + 7'd1 < 7'(nz)) nbz = z_reg + CW'(1);
            default: if (z_reg != '0) nbz = z_reg - CW'(1);
        endcase
        nb_self  = (nbx == x_reg) && (nby == y_reg) && (nbz == z_reg);
        w_sel    = (d_reg[2:1] == 2'd0) ? wx : (d_reg[2:1] == 2'd1) ? wy : wz;
        ctr_lin  = vfsor_pkg::lin_index(x_reg, y_reg, z_reg, nx, ny);
        nb_lin   = vfsor_pkg::lin_index(nbx, nby, nbz, nx, ny);
        last_vox = (x_reg == nx - CW'(1)) && (y_reg == ny - CW'(1)) && (z_reg == nz - CW'(1));
        skip_vox = !run_fill_reg && ((x_reg[0] ^ y_reg[0] ^ z_reg[0]) == colour_reg);
    end

    // Relaxed value, change and its magnitude
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            nv[c]    = vfsor_pkg::sat32(64'(old_reg[c]) + 64'(half_reg[c]));
            ch_w[c]  = 34'(nv[c]) - 34'(old_reg[c]);
            abs_w[c] = ch_reg[c][33] ? 34'(-ch_reg[c]) : 34'(ch_reg[c]);
        end
        gt_any = (abs_w[0] > 34'(precision_reg)) || (abs_w[1] > 34'(precision_reg)) ||
                 (abs_w[2] > 34'(precision_reg));
        sq_op  = (k_reg == 2'd3) ? precision_reg : abs_reg[k_reg];
    end

    // Sequencer: next state, memory and divider control
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        rd_en      = 1'b0;
        rd_lin     = ctr_lin;
        wr_lin     = ctr_lin;
        disp_we    = 1'b0;
        fix_we     = 1'b0;
        vis_we     = 1'b0;
        disp_wdata = fix_rdata[95:0];
        fix_wdata  = {s_data.is_constrained, s_data.fixed_z, s_data.fixed_y, s_data.fixed_x};
        vis_wdata  = 1'b1;
        out_load   = 1'b0;
        out_word   = '0;
        div_req    = '0;
        div_req.num = sum_reg[comp_reg];
        div_req.den = run_fill_reg ? ws_reg : ws_relax;
        case (state_reg)
            vfsor_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.mode)
                        vfsor_pkg::MODE_LOAD: begin
                            wr_lin     = LW'(s_data.voxel_index);
                            disp_wdata = {s_data.init_z, s_data.init_y, s_data.init_x};
                            disp_we    = in_range;
                            fix_we     = in_range;
                        end
                        vfsor_pkg::MODE_READ: begin
                            rd_en      = 1'b1;
                            rd_lin     = LW'(s_data.voxel_index);
                            state_next = vfsor_pkg::S_READ;
                        end
                        vfsor_pkg::MODE_FILL:  state_next = vfsor_pkg::S_INIT_RD;
                        default:               state_next = vfsor_pkg::S_SWEEP;
                    endcase
                end
            end
            vfsor_pkg::S_READ: begin
                if (!m_valid_reg || m_ready) begin
                    out_load        = 1'b1;
                    out_word.status = vfsor_pkg::STAT_READ;
                    if (in_range_reg) begin
                        out_word.out_x = disp_rdata[31:0];
                        out_word.out_y = disp_rdata[63:32];
                        out_word.out_z = disp_rdata[95:64];
                    end
                    state_next = vfsor_pkg::S_IDLE;
                end
            end
            vfsor_pkg::S_INIT_RD: begin
                rd_en      = 1'b1;
                rd_lin     = i_reg;
                state_next = vfsor_pkg::S_INIT_WR;
            end
            vfsor_pkg::S_INIT_WR: begin
                wr_lin     = i_reg;
                vis_we     = 1'b1;
                vis_wdata  = fix_rdata[96];
                disp_we    = fix_rdata[96];
                state_next = (i_reg == n_vox - LW'(1)) ? vfsor_pkg::S_INIT_END
                                                       : vfsor_pkg::S_INIT_RD;
            end
            vfsor_pkg::S_INIT_END: begin
                state_next = (count_reg == '0) ? vfsor_pkg::S_FINISH : vfsor_pkg::S_SWEEP;
            end
            vfsor_pkg::S_SWEEP: begin
                if (run_fill_reg) begin
                    state_next = (count_reg < n_vox && sweeps_reg < max_eff)
                               ? vfsor_pkg::S_VOX : vfsor_pkg::S_FINISH;
                end else begin
                    state_next = (!settled_reg && sweeps_reg < max_eff)
                               ? vfsor_pkg::S_VOX : vfsor_pkg::S_FINISH;
                end
            end
            vfsor_pkg::S_VOX: begin
                if (skip_vox) begin
                    state_next = vfsor_pkg::S_NEXT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = vfsor_pkg::S_CENTER;
                end
            end
            vfsor_pkg::S_CENTER: begin
                if (fix_rdata[96]) begin
                    disp_we    = 1'b1;
                    state_next = vfsor_pkg::S_NEXT;
                end else begin
                    state_next = vfsor_pkg::S_NB_RD;
                end
            end
            vfsor_pkg::S_NB_RD: begin
                rd_en      = 1'b1;
                rd_lin     = nb_lin;
                state_next = vfsor_pkg::S_NB_MUL;
            end
            vfsor_pkg::S_NB_MUL: state_next = vfsor_pkg::S_NB_ACC;
            vfsor_pkg::S_NB_ACC: begin
                state_next = (d_reg == DIR_LAST) ? vfsor_pkg::S_DIV_GO : vfsor_pkg::S_NB_RD;
            end
            vfsor_pkg::S_DIV_GO: begin
                if (run_fill_reg && ws_reg == '0) begin
                    state_next = vfsor_pkg::S_NEXT;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = vfsor_pkg::S_DIV_WAIT;
                end
            end
            vfsor_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    if (comp_reg != 2'd2) begin
                        state_next = vfsor_pkg::S_DIV_GO;
                    end else begin
                        state_next = run_fill_reg ? vfsor_pkg::S_FILL_WR : vfsor_pkg::S_RLX_D3;
                    end
                end
            end
            vfsor_pkg::S_FILL_WR: begin
                disp_we    = 1'b1;
                vis_we     = 1'b1;
                disp_wdata = {mean_reg[2], mean_reg[1], mean_reg[0]};
                state_next = vfsor_pkg::S_NEXT;
            end
            vfsor_pkg::S_RLX_D3:   state_next = vfsor_pkg::S_RLX_HALF;
            vfsor_pkg::S_RLX_HALF: state_next = vfsor_pkg::S_RLX_WR;
            vfsor_pkg::S_RLX_WR: begin
                disp_we    = 1'b1;
                disp_wdata = {nv[2], nv[1], nv[0]};
                state_next = vfsor_pkg::S_RLX_ABS;
            end
            vfsor_pkg::S_RLX_ABS: begin
                state_next = gt_any ? vfsor_pkg::S_NEXT : vfsor_pkg::S_RLX_SQ;
            end
            vfsor_pkg::S_RLX_SQ: begin
                if (k_reg == 2'd3) state_next = vfsor_pkg::S_RLX_CMP;
            end
            vfsor_pkg::S_RLX_CMP: state_next = vfsor_pkg::S_NEXT;
            vfsor_pkg::S_NEXT: begin
                if (!last_vox) begin
                    state_next = vfsor_pkg::S_VOX;
                end else if (!run_fill_reg && !colour_reg) begin
                    state_next = vfsor_pkg::S_VOX;
                end else begin
                    state_next = vfsor_pkg::S_SWEEP;
                end
            end
            vfsor_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load             = 1'b1;
                    out_word.status      = status_reg;
                    out_word.sweeps_used = sweeps_reg;
                    state_next           = vfsor_pkg::S_IDLE;
                end
            end
            default: state_next = vfsor_pkg::S_IDLE;
        endcase
    end

    // State register and output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vfsor_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_data_reg <= out_word;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_x_reg   <= vfsor_pkg::RST_WEIGHT;
            weight_y_reg   <= vfsor_pkg::RST_WEIGHT;
            weight_z_reg   <= vfsor_pkg::RST_WEIGHT;
            precision_reg  <= vfsor_pkg::RST_PRECISION;
            max_sweeps_reg <= vfsor_pkg::RST_MAX_SWEEPS;
            size_x_reg     <= vfsor_pkg::RST_SIZE;
            size_y_reg     <= vfsor_pkg::RST_SIZE;
            size_z_reg     <= vfsor_pkg::RST_SIZE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vfsor_pkg::REG_WEIGHT_X:   weight_x_reg   <= cfg_wdata[23:0];
                vfsor_pkg::REG_WEIGHT_Y:   weight_y_reg   <= cfg_wdata[23:0];
                vfsor_pkg::REG_WEIGHT_Z:   weight_z_reg   <= cfg_wdata[23:0];
                vfsor_pkg::REG_PRECISION:  precision_reg  <= cfg_wdata;
                vfsor_pkg::REG_MAX_SWEEPS: max_sweeps_reg <= cfg_wdata[15:0];
                vfsor_pkg::REG_SIZE_X:     size_x_reg     <= cfg_wdata[5:0];
                vfsor_pkg::REG_SIZE_Y:     size_y_reg     <= cfg_wdata[5:0];
                vfsor_pkg::REG_SIZE_Z:     size_z_reg     <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Sequencer datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            vfsor_pkg::S_IDLE: begin
                run_fill_reg <= (s_data.mode == vfsor_pkg::MODE_FILL);
                in_range_reg <= in_range;
                i_reg        <= '0;
                count_reg    <= '0;
                sweeps_reg   <= '0;
                settled_reg  <= 1'b0;
            end
            vfsor_pkg::S_INIT_WR: begin
                i_reg     <= i_reg + LW'(1);
                count_reg <= count_reg + LW'(fix_rdata[96]);
            end
            vfsor_pkg::S_INIT_END: begin
                status_reg <= vfsor_pkg::STAT_NO_CONSTR;
            end
            vfsor_pkg::S_SWEEP: begin
                x_reg      <= '0;
                y_reg      <= '0;
                z_reg      <= '0;
                colour_reg <= 1'b0;
                if (run_fill_reg) begin
                    if (count_reg < n_vox && sweeps_reg < max_eff) begin
                        sweeps_reg <= sweeps_reg + 16'd1;
                    end
                    status_reg <= (count_reg >= n_vox) ? vfsor_pkg::STAT_FILL_DONE
                                                       : vfsor_pkg::STAT_LIMIT;
                end else begin
                    if (!settled_reg && sweeps_reg < max_eff) begin
                        sweeps_reg  <= sweeps_reg + 16'd1;
                        settled_reg <= 1'b1;
                    end
                    status_reg <= settled_reg ? vfsor_pkg::STAT_CONVERGED
                                              : vfsor_pkg::STAT_LIMIT;
                end
            end
            vfsor_pkg::S_CENTER: begin
                old_reg[0] <= disp_rdata[31:0];
                old_reg[1] <= disp_rdata[63:32];
                old_reg[2] <= disp_rdata[95:64];
                vp_reg     <= vis_rdata[0];
                ws_reg     <= '0;
                d_reg      <= '0;
                comp_reg   <= '0;
                for (int c = 0; c < 3; c++) sum_reg[c] <= '0;
            end
            vfsor_pkg::S_NB_MUL: begin
                use_reg     <= !run_fill_reg || (nb_self ? vp_reg : vis_rdata[0]);
                prod_reg[0] <= $signed({1'b0, w_sel}) * $signed(disp_rdata[31:0]);
                prod_reg[1] <= $signed({1'b0, w_sel}) * $signed(disp_rdata[63:32]);
                prod_reg[2] <= $signed({1'b0, w_sel}) * $signed(disp_rdata[95:64]);
            end
            vfsor_pkg::S_NB_ACC: begin
                d_reg <= d_reg + 3'd1;
                if (use_reg) begin
                    for (int c = 0; c < 3; c++) sum_reg[c] <= sum_reg[c] + 64'(prod_reg[c]);
                    ws_reg <= ws_reg + vfsor_pkg::DENW'(w_sel);
                    if (run_fill_reg && !vp_reg) begin
                        vp_reg    <= 1'b1;
                        count_reg <= count_reg + LW'(1);
                    end
                end
            end
            vfsor_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    mean_reg[comp_reg] <= div_rsp.quot;
                    comp_reg           <= comp_reg + 2'd1;
                end
            end
            vfsor_pkg::S_RLX_D3: begin
                for (int c = 0; c < 3; c++) begin
                    d3_reg[c] <= 35'(33'(mean_reg[c]) - 33'(old_reg[c])) * 35'sd3;
                end
            end
            vfsor_pkg::S_RLX_HALF: begin
                for (int c = 0; c < 3; c++) begin
                    half_reg[c] <= d3_reg[c][34] ? -((-d3_reg[c] + 35'sd1) >>> 1)
                                                 : (d3_reg[c] + 35'sd1) >>> 1;
                end
            end
            vfsor_pkg::S_RLX_WR: begin
                for (int c = 0; c < 3; c++) ch_reg[c] <= ch_w[c];
            end
            vfsor_pkg::S_RLX_ABS: begin
                for (int c = 0; c < 3; c++) abs_reg[c] <= abs_w[c][30:0];
                if (gt_any) settled_reg <= 1'b0;
                k_reg      <= '0;
                sq_reg     <= '0;
                sq_sum_reg <= '0;
            end
            vfsor_pkg::S_RLX_SQ: begin
                sq_reg     <= sq_op * sq_op;
                sq_sum_reg <= sq_sum_reg + 64'(sq_reg);
                k_reg      <= k_reg + 2'd1;
            end
            vfsor_pkg::S_RLX_CMP: begin
                if (sq_sum_reg > 64'(sq_reg)) settled_reg <= 1'b0;
            end
            vfsor_pkg::S_NEXT: begin
                if (x_reg != nx - CW'(1)) begin
                    x_reg <= x_reg + CW'(1);
                end else begin
                    x_reg <= '0;
                    if (y_reg != ny - CW'(1)) begin
                        y_reg <= y_reg + CW'(1);
                    end else begin
                        y_reg <= '0;
                        z_reg <= (z_reg != nz - CW'(1)) ? z_reg + CW'(1) : '0;
                    end
                end
                if (last_vox) colour_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    // Voxel stores
    vfsor_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_disp_ram (
        .aclk  (aclk),
        .we    (disp_we),
        .waddr (AW'(wr_lin)),
        .wdata (disp_wdata),
        .re    (rd_en),
        .raddr (AW'(rd_lin)),
        .rdata (disp_rdata)
    );

    vfsor_ram #(.WIDTH(97), .DEPTH(DEPTH)) u_fix_ram (
        .aclk  (aclk),
        .we    (fix_we),
        .waddr (AW'(wr_lin)),
        .wdata (fix_wdata),
        .re    (rd_en),
        .raddr (AW'(rd_lin)),
        .rdata (fix_rdata)
    );

    vfsor_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis_ram (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (AW'(wr_lin)),
        .wdata (vis_wdata),
        .re    (rd_en),
        .raddr (AW'(rd_lin)),
        .rdata (vis_rdata)
    );

    // Shared rounding divider
    vfsor_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
